FILE: sv/tbeq_pkg.sv
// Package for the three-band equalizer: widths, register codes, config struct.
// Used by every module of the block and by the channel interfaces.
// No dependencies.
package tbeq_pkg;

  // Default sample and filter state widths
  localparam int SAMPLE_WIDTH = 24;
  localparam int STATE_WIDTH  = 32;

  // Coefficient and gain formats
  localparam int COEF_WIDTH = 17;
  localparam int GAIN_WIDTH = 16;
  localparam int COEF_FRAC  = 16;
  localparam int GAIN_FRAC  = 12;

  // Second multiplier operand: unsigned coefficient plus sign bit
  localparam int MUL_B_WIDTH = COEF_WIDTH + 1;

  // Filter structure
  localparam int STAGE_COUNT = 4;
  localparam int STAGE_IDX_W = $clog2(STAGE_COUNT);
  localparam int HISTORY_DEPTH = 3;

  // Configuration channel
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_WIDTH;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_COEF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;

  localparam logic signed [GAIN_WIDTH-1:0] GAIN_UNITY = 16'sd4096;

  typedef struct packed {
    logic        [COEF_WIDTH-1:0] low_coef;
    logic        [COEF_WIDTH-1:0] high_coef;
    logic signed [GAIN_WIDTH-1:0] low_gain;
    logic signed [GAIN_WIDTH-1:0] mid_gain;
    logic signed [GAIN_WIDTH-1:0] high_gain;
  } cfg_t;

endpackage

FILE: sv/tbeq_if.sv
// Channel interfaces of the equalizer: sample in, sample out, register write.
// Depends on tbeq_pkg for widths.

interface tbeq_in_if #(
  parameter int SAMPLE_WIDTH = tbeq_pkg::SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface tbeq_out_if #(
  parameter int SAMPLE_WIDTH = tbeq_pkg::SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface tbeq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tbeq_pkg::CFG_IDX_W-1:0]   index;
  logic [tbeq_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/three_band_equalizer_top.sv
// Three-band equalizer: eight one-pole stages and three gains on one multiplier.
// Each input sample runs through a multiply and an update step for each active stage,
// where the active stages number 8, 4 with one bank idle, 0 with both idle; then a
// gain and an accumulate step for each band, then the output register, which waits
// while the sink holds a prior result. A new sample is taken only in idle, once the
// result of the last one is loaded out, since the single multiplier is shared.
// Reset (rst_n low, synchronous): stages and history cleared, gains 1.0, coefs 0.
module three_band_equalizer_top #(
  parameter int SAMPLE_WIDTH = tbeq_pkg::SAMPLE_WIDTH,
  parameter int STATE_WIDTH  = tbeq_pkg::STATE_WIDTH
) (
  input logic        clk,
  input logic        rst_n,
  tbeq_in_if.sink    in_chan,
  tbeq_out_if.source out_chan,
  tbeq_cfg_if.sink   cfg_chan
);

  localparam int SW    = STATE_WIDTH;
  localparam int SMP   = SAMPLE_WIDTH;
  localparam int AW    = SW + 3;
  localparam int BW    = tbeq_pkg::MUL_B_WIDTH;
  localparam int RW    = AW + BW - tbeq_pkg::GAIN_FRAC;
  localparam int UW    = RW + 1;
  localparam int ACC_W = RW + 2;
  localparam int TSHL  = (SW >= SMP) ? (SW - SMP) : 0;
  localparam int TSHR  = (SMP > SW) ? (SMP - SW) : 0;
  localparam int XW    = SMP + TSHL;
  localparam int CW    = ACC_W + TSHR;
  localparam int SIW   = tbeq_pkg::STAGE_IDX_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_GAIN = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam logic BANK_LOW  = 1'b0;
  localparam logic BANK_HIGH = 1'b1;

  localparam logic [1:0] BAND_LOW  = 2'd0;
  localparam logic [1:0] BAND_MID  = 2'd1;
  localparam logic [1:0] BAND_HIGH = 2'd2;

  localparam logic [SIW-1:0] LAST_STAGE = SIW'(tbeq_pkg::STAGE_COUNT - 1);

  localparam logic signed [SW-1:0]  STATE_MAX  = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]  STATE_MIN  = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SMP-1:0] SAMPLE_MAX = {1'b0, {(SMP-1){1'b1}}};
  localparam logic signed [SMP-1:0] SAMPLE_MIN = {1'b1, {(SMP-1){1'b0}}};

  // Sample format to state format
  function automatic logic signed [SW-1:0] to_state(input logic signed [SMP-1:0] s);
    logic signed [XW-1:0] w;
    w = XW'(s);
    w = w <<< TSHL;
    w = w >>> TSHR;
    return $signed(w[SW-1:0]);
  endfunction

  tbeq_pkg::cfg_t cfg;

  logic [2:0]     state_r, state_nxt;
  logic           bank_r, bank_nxt;
  logic [SIW-1:0] stg_r, stg_nxt;
  logic [1:0]     gstep_r, gstep_nxt;
  logic           en_low_r, en_low_nxt;
  logic           en_high_r, en_high_nxt;
  logic signed [SW-1:0]    x_r, x_nxt;
  logic signed [SW-1:0]    lo_r, lo_nxt;
  logic signed [SW-1:0]    hl_r, hl_nxt;
  logic signed [SMP-1:0]   sample_r, sample_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SMP-1:0]   out_data_r, out_data_nxt;

  logic signed [SW-1:0]  banks_r [2*tbeq_pkg::STAGE_COUNT];
  logic signed [SMP-1:0] hist_r  [tbeq_pkg::HISTORY_DEPTH];

  logic                  in_acc;
  logic                  out_load;
  logic                  bank_we;
  logic [SIW:0]          bank_addr;
  logic signed [SW-1:0]  cur;
  logic signed [SW-1:0]  delayed;
  logic signed [UW-1:0]  upd_sum;
  logic signed [SW-1:0]  upd_new;
  logic signed [AW-1:0]  hi_band;
  logic signed [AW-1:0]  mid_band;
  logic signed [AW-1:0]  band_sel;
  logic signed [tbeq_pkg::GAIN_WIDTH-1:0] gain_sel;
  logic [tbeq_pkg::COEF_WIDTH-1:0] coef_sel;
  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic                  mul_coef;
  logic signed [RW-1:0]  mul_res;
  logic signed [CW-1:0]  conv;

  tbeq_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  tbeq_mul #(
    .A_WIDTH (AW),
    .B_WIDTH (BW)
  ) u_mul (
    .clk       (clk),
    .coef_mode (mul_coef),
    .a         (mul_a),
    .b         (mul_b),
    .res_r     (mul_res)
  );

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign in_acc              = in_chan.valid && in_chan.ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_data_r;
  assign out_load            = (state_r == ST_OUT) && (!out_valid_r || out_chan.ready);

  // Stage read, band forming and multiplier operand selection
  always_comb begin
    bank_addr = {bank_r, stg_r};
    cur       = banks_r[bank_addr];
    delayed   = to_state(hist_r[tbeq_pkg::HISTORY_DEPTH-1]);
    coef_sel  = (bank_r == BANK_HIGH) ? cfg.high_coef : cfg.low_coef;

    hi_band  = en_high_r ? (AW'(delayed) - AW'(hl_r)) : '0;
    mid_band = AW'(delayed) - (hi_band + AW'(lo_r));

    unique case (gstep_r)
      BAND_LOW: begin
        band_sel = AW'(lo_r);
        gain_sel = cfg.low_gain;
      end
      BAND_MID: begin
        band_sel = mid_band;
        gain_sel = cfg.mid_gain;
      end
      default: begin
        band_sel = hi_band;
        gain_sel = cfg.high_gain;
      end
    endcase

    mul_coef = (state_r == ST_MUL);
    if (mul_coef) begin
      mul_a = AW'(x_r) - AW'(cur);
      mul_b = $signed({1'b0, coef_sel});
    end else begin
      mul_a = band_sel;
      mul_b = BW'(gain_sel);
    end

    // Stage update with saturation to the state range
    upd_sum = UW'(cur) + UW'(mul_res);
    if ((&upd_sum[UW-1:SW-1]) || !(|upd_sum[UW-1:SW-1])) begin
      upd_new = $signed(upd_sum[SW-1:0]);
    end else begin
      upd_new = upd_sum[UW-1] ? STATE_MIN : STATE_MAX;
    end

    // Sum to sample format; saturation is applied when the result is loaded
    conv = CW'(acc_r);
    conv = conv <<< TSHR;
    conv = conv >>> TSHL;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    bank_nxt      = bank_r;
    stg_nxt       = stg_r;
    gstep_nxt     = gstep_r;
    en_low_nxt    = en_low_r;
    en_high_nxt   = en_high_r;
    x_nxt         = x_r;
    lo_nxt        = lo_r;
    hl_nxt        = hl_r;
    sample_nxt    = sample_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    bank_we       = 1'b0;

    // Drop the result once the sink takes it
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sample_nxt  = in_chan.sample_in;
          x_nxt       = to_state(in_chan.sample_in);
          en_low_nxt  = (cfg.low_gain != '0) || (cfg.mid_gain != '0);
          en_high_nxt = (cfg.high_gain != '0) || (cfg.mid_gain != '0);
          stg_nxt     = '0;
          gstep_nxt   = BAND_LOW;
          lo_nxt      = '0;
          hl_nxt      = '0;
          acc_nxt     = '0;
          if (en_low_nxt) begin
            bank_nxt  = BANK_LOW;
            state_nxt = ST_MUL;
          end else if (en_high_nxt) begin
            bank_nxt  = BANK_HIGH;
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_GAIN;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        bank_we = 1'b1;
        x_nxt   = upd_new;
        if (stg_r == LAST_STAGE) begin
          stg_nxt = '0;
          if (bank_r == BANK_LOW) begin
            lo_nxt = upd_new;
            if (en_high_r) begin
              bank_nxt  = BANK_HIGH;
              x_nxt     = to_state(sample_r);
              state_nxt = ST_MUL;
            end else begin
              state_nxt = ST_GAIN;
            end
          end else begin
            hl_nxt    = upd_new;
            state_nxt = ST_GAIN;
          end
        end else begin
          stg_nxt   = stg_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_GAIN: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = acc_r + ACC_W'(mul_res);
        if (gstep_r == BAND_HIGH) begin
          state_nxt = ST_OUT;
        end else begin
          gstep_nxt = gstep_r + 1'b1;
          state_nxt = ST_GAIN;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if ((&conv[CW-1:SMP-1]) || !(|conv[CW-1:SMP-1])) begin
            out_data_nxt = $signed(conv[SMP-1:0]);
          end else begin
            out_data_nxt = conv[CW-1] ? SAMPLE_MIN : SAMPLE_MAX;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 2*tbeq_pkg::STAGE_COUNT; i++) begin
        banks_r[i] <= '0;
      end
      for (int i = 0; i < tbeq_pkg::HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (bank_we) begin
        banks_r[bank_addr] <= upd_new;
      end
      // Advance the input history once the result is issued
      if (out_load) begin
        for (int i = tbeq_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
          hist_r[i] <= hist_r[i-1];
        end
        hist_r[0] <= sample_r;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    bank_r     <= bank_nxt;
    stg_r      <= stg_nxt;
    gstep_r    <= gstep_nxt;
    en_low_r   <= en_low_nxt;
    en_high_r  <= en_high_nxt;
    x_r        <= x_nxt;
    lo_r       <= lo_nxt;
    hl_r       <= hl_nxt;
    sample_r   <= sample_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // A new transaction starts with a cleared sum and leaves idle
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (acc_r == '0) && (state_r != ST_IDLE))
    else $error("accepted sample did not start with a cleared sum");

  // The history takes the sample whose result was just issued
  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (hist_r[0] == $past(sample_r)) && out_valid_r)
    else $error("history not advanced with the issued result");

  // The low bank is only updated while it is enabled
  a_low_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && bank_r == BANK_LOW) |-> en_low_r)
    else $error("disabled low bank updated");

endmodule

FILE: sv/tbeq_cfg.sv
// Configuration register file of the equalizer: coefficients and band gains.
// Depends on tbeq_pkg and the tbeq_cfg_if interface.
module tbeq_cfg (
  input  logic           clk,
  input  logic           rst_n,
  tbeq_cfg_if.sink       cfg_chan,
  output tbeq_pkg::cfg_t cfg
);

  tbeq_pkg::cfg_t cfg_r;
  tbeq_pkg::cfg_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  // Decode a write transaction; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        tbeq_pkg::REG_LOW_COEF:  cfg_nxt.low_coef  = cfg_chan.data[tbeq_pkg::COEF_WIDTH-1:0];
        tbeq_pkg::REG_HIGH_COEF: cfg_nxt.high_coef = cfg_chan.data[tbeq_pkg::COEF_WIDTH-1:0];
        tbeq_pkg::REG_LOW_GAIN:  cfg_nxt.low_gain  = $signed(cfg_chan.data[tbeq_pkg::GAIN_WIDTH-1:0]);
        tbeq_pkg::REG_MID_GAIN:  cfg_nxt.mid_gain  = $signed(cfg_chan.data[tbeq_pkg::GAIN_WIDTH-1:0]);
        tbeq_pkg::REG_HIGH_GAIN: cfg_nxt.high_gain = $signed(cfg_chan.data[tbeq_pkg::GAIN_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_coef  <= '0;
      cfg_r.high_coef <= '0;
      cfg_r.low_gain  <= tbeq_pkg::GAIN_UNITY;
      cfg_r.mid_gain  <= tbeq_pkg::GAIN_UNITY;
      cfg_r.high_gain <= tbeq_pkg::GAIN_UNITY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: sv/tbeq_mul.sv
// Shared multiply unit: exact signed product, floor-shifted by the
// coefficient or the gain fraction, registered. Depends on tbeq_pkg.
module tbeq_mul #(
  parameter int A_WIDTH = tbeq_pkg::STATE_WIDTH + 3,
  parameter int B_WIDTH = tbeq_pkg::MUL_B_WIDTH
) (
  input  logic                                             clk,
  input  logic                                             coef_mode,
  input  logic signed [A_WIDTH-1:0]                        a,
  input  logic signed [B_WIDTH-1:0]                        b,
  output logic signed [A_WIDTH+B_WIDTH-tbeq_pkg::GAIN_FRAC-1:0] res_r
);

  localparam int P_WIDTH = A_WIDTH + B_WIDTH;
  localparam int R_WIDTH = P_WIDTH - tbeq_pkg::GAIN_FRAC;

  logic signed [P_WIDTH-1:0] prod;
  logic signed [P_WIDTH-1:0] shifted;
  logic signed [R_WIDTH-1:0] res_nxt;

  // Multiply, then arithmetic shift (rounds toward minus infinity)
  always_comb begin
    prod    = P_WIDTH'(a) * P_WIDTH'(b);
    shifted = coef_mode ? (prod >>> tbeq_pkg::COEF_FRAC) : (prod >>> tbeq_pkg::GAIN_FRAC);
    res_nxt = $signed(shifted[R_WIDTH-1:0]);
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

FILE: tb/three_band_equalizer_checker.sv
`timescale 1ns / 1ps
// Checker for the three-band equalizer: watches the sample and register channels,
// predicts every output sample and compares it with what the block returns.
// Depends on tbeq_pkg and the channel interfaces in tbeq_if.
module three_band_equalizer_checker
  import tbeq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tbeq_in_if   in_mon,
  tbeq_out_if  out_mon,
  tbeq_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_count
);

  localparam int FMT_SHIFT = STATE_WIDTH - SAMPLE_WIDTH;

  typedef logic signed [SAMPLE_WIDTH-1:0] pcm_t;
  typedef logic signed [STATE_WIDTH-1:0]  stage_t;

  // Shadow copy of the register file and of the filter state
  cfg_t    eq_cfg;
  stage_t  low_bank  [STAGE_COUNT];
  stage_t  high_bank [STAGE_COUNT];
  pcm_t    history   [HISTORY_DEPTH];
  pcm_t    expected_samples [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic longint saturate_to(input longint v, input int w);
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) <<< (w - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (v > hi_lim) return hi_lim;
    if (v < lo_lim) return lo_lim;
    return v;
  endfunction

  // Exact product, then floor shift by the fraction bits
  function automatic longint product_floor(input longint v, input longint g, input int frac);
    return (v * g) >>> frac;
  endfunction

  // Advance one bank of cascaded one-pole stages; return the last stage
  function automatic longint run_cascade(input bit high_side, input longint x,
                                         input longint coef);
    longint acc;
    longint prev;
    acc = x;
    for (int i = 0; i < STAGE_COUNT; i++) begin
      prev = high_side ? longint'(high_bank[i]) : longint'(low_bank[i]);
      prev = saturate_to(prev + product_floor(acc - prev, coef, COEF_FRAC), STATE_WIDTH);
      if (high_side) high_bank[i] = stage_t'(prev);
      else low_bank[i] = stage_t'(prev);
      acc = prev;
    end
    return acc;
  endfunction

  // Work out one output sample and advance the filter state
  function automatic pcm_t equalize(input pcm_t sample);
    longint x;
    longint delayed;
    longint gl;
    longint gm;
    longint gh;
    longint lo_band;
    longint hi_band;
    longint mid_band;
    longint total;
    x       = longint'(sample) <<< FMT_SHIFT;
    delayed = longint'(history[HISTORY_DEPTH-1]) <<< FMT_SHIFT;
    gl      = longint'($signed(eq_cfg.low_gain));
    gm      = longint'($signed(eq_cfg.mid_gain));
    gh      = longint'($signed(eq_cfg.high_gain));
    lo_band = 0;
    hi_band = 0;
    // A bank whose band gain and mid gain are both zero stays frozen
    if (gl != 0 || gm != 0)
      lo_band = run_cascade(1'b0, x, longint'(eq_cfg.low_coef));
    if (gh != 0 || gm != 0)
      hi_band = delayed - run_cascade(1'b1, x, longint'(eq_cfg.high_coef));
    mid_band = delayed - (hi_band + lo_band);
    total = product_floor(lo_band, gl, GAIN_FRAC) + product_floor(mid_band, gm, GAIN_FRAC)
          + product_floor(hi_band, gh, GAIN_FRAC);
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = sample;
    return pcm_t'(saturate_to(total >>> FMT_SHIFT, SAMPLE_WIDTH));
  endfunction

  always @(posedge clk) begin
    pcm_t want;
    if (!rst_n) begin
      eq_cfg.low_coef  = '0;
      eq_cfg.high_coef = '0;
      eq_cfg.low_gain  = GAIN_UNITY;
      eq_cfg.mid_gain  = GAIN_UNITY;
      eq_cfg.high_gain = GAIN_UNITY;
      foreach (low_bank[i]) begin
        low_bank[i]  = '0;
        high_bank[i] = '0;
      end
      foreach (history[i]) history[i] = '0;
      expected_samples.delete();
      fail_count = 0;
    end else begin
      // Track register writes; unmapped indexes are dropped
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_LOW_COEF:  eq_cfg.low_coef  = cfg_mon.data[COEF_WIDTH-1:0];
          REG_HIGH_COEF: eq_cfg.high_coef = cfg_mon.data[COEF_WIDTH-1:0];
          REG_LOW_GAIN:  eq_cfg.low_gain  = cfg_mon.data[GAIN_WIDTH-1:0];
          REG_MID_GAIN:  eq_cfg.mid_gain  = cfg_mon.data[GAIN_WIDTH-1:0];
          REG_HIGH_GAIN: eq_cfg.high_gain = cfg_mon.data[GAIN_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_samples.push_back(equalize(in_mon.sample_in));
      // Compare each output transaction with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("output %0d with no sample pending", out_mon.sample_out));
        end else begin
          want = expected_samples.pop_front();
          if (out_mon.sample_out !== want)
            report_mismatch($sformatf("sample_out %0d, expected %0d",
                                      out_mon.sample_out, want));
        end
      end
    end
    pending_count <= expected_samples.size();
  end

endmodule

FILE: tb/three_band_equalizer_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the three-band equalizer: clock, reset, stimulus and verdict.
// Depends on tbeq_pkg, tbeq_if, the block and three_band_equalizer_checker.
module three_band_equalizer_top_test;
  import tbeq_pkg::*;

  typedef logic signed [SAMPLE_WIDTH-1:0] pcm_t;
  typedef logic signed [GAIN_WIDTH-1:0]   gain_t;
  typedef logic [COEF_WIDTH-1:0]          coef_t;

  localparam pcm_t    SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam pcm_t    SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam coef_t   COEF_MAX   = '1;
  localparam coef_t   COEF_ONE   = coef_t'(1 << COEF_FRAC);
  localparam gain_t   GAIN_MAX   = {1'b0, {(GAIN_WIDTH-1){1'b1}}};
  localparam gain_t   GAIN_MIN   = {1'b1, {(GAIN_WIDTH-1){1'b0}}};

  localparam int PHASE_COUNT        = 3;
  localparam int SETTINGS_PER_PHASE = 6;
  localparam int ITEMS_PER_SETTING  = 72;
  localparam int DRAIN_CYCLES       = 40;
  localparam int STALL_LIMIT        = 2000;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   fail_count;
  int   pending_count;
  int   stall_cycles;
  int   send_idle_pcts [PHASE_COUNT] = '{10, 68, 0};
  int   recv_idle_pcts [PHASE_COUNT] = '{68, 10, 0};

  tbeq_in_if  in_chan ();
  tbeq_out_if out_chan ();
  tbeq_cfg_if cfg_chan ();

  three_band_equalizer_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  three_band_equalizer_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_mon       (cfg_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Random backpressure on the output channel
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || (cfg_chan.valid && cfg_chan.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("three_band_equalizer_top_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_sample(input pcm_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.sample_in <= value;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Hold valid high across back-to-back writes; the caller drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
  endtask

  // Drain the block, then rewrite every register plus one unmapped index
  task automatic apply_settings(input coef_t lc, input coef_t hc,
                                input gain_t lg, input gain_t mg, input gain_t hg);
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    write_reg(REG_HIGH_GAIN + CFG_IDX_W'($urandom_range(3, 1)), CFG_DATA_W'($urandom()));
    write_reg(REG_LOW_COEF, lc);
    write_reg(REG_HIGH_COEF, hc);
    write_reg(REG_LOW_GAIN, {1'($urandom_range(1)), lg});
    write_reg(REG_MID_GAIN, {1'($urandom_range(1)), mg});
    write_reg(REG_HIGH_GAIN, {1'($urandom_range(1)), hg});
    cfg_chan.valid <= 1'b0;
  endtask

  function automatic coef_t random_coef();
    case ($urandom_range(5))
      0: return '0;
      1: return COEF_MAX;
      default: return coef_t'($urandom());
    endcase
  endfunction

  function automatic gain_t random_gain();
    case ($urandom_range(7))
      0: return '0;
      1: return GAIN_MAX;
      2: return GAIN_MIN;
      3: return GAIN_UNITY;
      default: return gain_t'($urandom());
    endcase
  endfunction

  function automatic pcm_t random_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return pcm_t'(int'($urandom_range(511)) - 256);
      default: return pcm_t'($urandom());
    endcase
  endfunction

  initial begin
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.sample_in <= '0;
    cfg_chan.valid    <= 1'b0;
    cfg_chan.index    <= '0;
    cfg_chan.data     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = send_idle_pcts[0];
    recv_idle_pct = recv_idle_pcts[0];

    // Reset defaults: zero coefficients, unity gains
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(pcm_t'(-1));
    send_sample(pcm_t'(1));

    // Coefficients near 2.0 and extreme gains: stage and output saturation
    apply_settings(COEF_MAX, COEF_MAX, GAIN_MAX, GAIN_MIN, GAIN_MAX);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX);

    // Low bank frozen: low and mid gains zero
    apply_settings(coef_t'(20000), COEF_MAX, '0, '0, GAIN_MIN);
    for (int i = 0; i < 4; i++) send_sample(random_sample());

    // High bank frozen: high and mid gains zero
    apply_settings(COEF_ONE, '0, GAIN_MIN, '0, '0);
    for (int i = 0; i < 4; i++) send_sample(random_sample());

    // Both banks frozen, all gains zero
    apply_settings('0, '0, '0, '0, '0);
    for (int i = 0; i < 3; i++) send_sample(random_sample());

    // Random settings and samples under each backpressure mix
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      send_idle_pct = send_idle_pcts[phase];
      recv_idle_pct = recv_idle_pcts[phase];
      for (int setting = 0; setting < SETTINGS_PER_PHASE; setting++) begin
        apply_settings(random_coef(), random_coef(), random_gain(), random_gain(),
                       random_gain());
        repeat (ITEMS_PER_SETTING) send_sample(random_sample());
      end
    end

    // Wait for the last results, then give the verdict
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("three_band_equalizer_top_test: PASS");
    end else begin
      $display("three_band_equalizer_top_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/tbeq_pkg.sv
sv/tbeq_if.sv
sv/tbeq_cfg.sv
sv/tbeq_mul.sv
sv/three_band_equalizer_top.sv
tb/three_band_equalizer_checker.sv
tb/three_band_equalizer_top_test.sv
